>>> rtl/lrrle_pkg.sv
`timescale 1ns / 1ps

package lrrle_pkg;

  // Longest literal run that is held before it is sent.
  localparam int MAX_LITERAL = 32;
  // Longest repeat run that one header can carry.
  localparam int MAX_REPEAT = 99;
  // A literal header carries this base plus the run length.
  localparam int LIT_HDR_BASE = 100;

  localparam int BYTE_W = 8;
  localparam int VALUE_W = 10;
  localparam int KIND_W = 2;
  localparam int RUN_W = 7;
  localparam int LIT_AW = $clog2(MAX_LITERAL);
  localparam int LIT_CW = $clog2(MAX_LITERAL + 1);

  // Group kinds.
  localparam logic [KIND_W-1:0] KIND_REPEAT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LITERAL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BYTE = 2'd2;

  // One code group as it leaves the sequencer.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [KIND_W-1:0]  kind;
    logic               step_done;
    logic               code_end;
  } group_t;

endpackage

>>> rtl/lrrle_ram.sv
`timescale 1ns / 1ps

module lrrle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/lrrle_out.sv
`timescale 1ns / 1ps

module lrrle_out (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  grp_valid,
  input  lrrle_pkg::group_t     grp,
  output logic                  grp_ready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,   // [9:0] group_value, rest zero
  output logic [2:0]            out_tuser,   // [1:0] group_kind, [2] step_done
  output logic                  out_tlast
);

  logic              valid_r;
  logic              valid_nxt;
  lrrle_pkg::group_t grp_r;

  // The register takes a new group when empty or when its group leaves now.
  assign grp_ready = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (grp_ready) begin
      valid_nxt = grp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_ready && grp_valid) begin
      grp_r <= grp;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(16 - lrrle_pkg::VALUE_W){1'b0}}, grp_r.value};
  assign out_tuser  = {grp_r.step_done, grp_r.kind};
  assign out_tlast  = grp_r.code_end;

endmodule

>>> rtl/lrrle_ctrl.sv
`timescale 1ns / 1ps

module lrrle_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [lrrle_pkg::BYTE_W-1:0]   in_byte,
  input  logic                           in_last,
  output logic                           grp_valid,
  output lrrle_pkg::group_t              grp,
  input  logic                           grp_ready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_STEP  = 3'd1;
  localparam logic [2:0] S_LAST  = 3'd2;
  localparam logic [2:0] S_LHDR  = 3'd3;
  localparam logic [2:0] S_LBYTE = 3'd4;
  localparam logic [2:0] S_RHDR  = 3'd5;
  localparam logic [2:0] S_RBYTE = 3'd6;

  localparam int BW = lrrle_pkg::BYTE_W;
  localparam int RW = lrrle_pkg::RUN_W;
  localparam int AW = lrrle_pkg::LIT_AW;
  localparam int CW = lrrle_pkg::LIT_CW;
  localparam int VW = lrrle_pkg::VALUE_W;

  logic [2:0]    state_r, state_nxt;
  logic [BW-1:0] byte_r, byte_nxt;
  logic          last_r, last_nxt;
  logic          flush_r, flush_nxt;
  logic [BW-1:0] held_r, held_nxt;
  logic [RW-1:0] run_r, run_nxt;
  logic [CW-1:0] lit_cnt_r, lit_cnt_nxt;
  logic [AW-1:0] idx_r, idx_nxt;

  logic          wr_en;
  logic [BW-1:0] rd_data;
  logic [CW-1:0] lit_cnt_inc;
  logic [CW-1:0] lit_last_idx;
  logic [2:0]    after_main;
  logic          run_full;

  assign in_tready    = (state_r == S_IDLE);
  assign lit_cnt_inc  = lit_cnt_r + CW'(1);
  assign lit_last_idx = lit_cnt_r - CW'(1);
  assign run_full     = (run_r >= RW'(lrrle_pkg::MAX_REPEAT));
  // Where to go once the byte's own work is done.
  assign after_main   = last_r ? S_LAST : S_IDLE;

  // Literal store: written at the fill count, read ahead at the next index.
  lrrle_ram #(
    .WIDTH (BW),
    .DEPTH (lrrle_pkg::MAX_LITERAL)
  ) u_lit_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (lit_cnt_r[AW-1:0]),
    .wr_data (held_r),
    .rd_addr (idx_nxt),
    .rd_data (rd_data)
  );

  // Sequencer: decides the step, then sends groups one per cycle while grp_ready is high.
  always_comb begin
    state_nxt   = state_r;
    byte_nxt    = byte_r;
    last_nxt    = last_r;
    flush_nxt   = flush_r;
    held_nxt    = held_r;
    run_nxt     = run_r;
    lit_cnt_nxt = lit_cnt_r;
    idx_nxt     = idx_r;
    wr_en       = 1'b0;
    grp_valid   = 1'b0;
    grp         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          byte_nxt  = in_byte;
          last_nxt  = in_last;
          flush_nxt = 1'b0;
          state_nxt = S_STEP;
        end
      end

      S_STEP: begin
        if (run_r == '0) begin
          // Nothing held yet: this byte starts a run.
          held_nxt  = byte_r;
          run_nxt   = RW'(1);
          state_nxt = after_main;
        end else if (byte_r == held_r) begin
          if (run_r == RW'(1)) begin
            // A repeat run starts, so the pending literal run goes out.
            run_nxt = RW'(2);
            if (lit_cnt_r != '0) begin
              state_nxt = S_LHDR;
            end else begin
              state_nxt = after_main;
            end
          end else if (run_full) begin
            state_nxt = S_RHDR;
          end else begin
            run_nxt   = run_r + RW'(1);
            state_nxt = after_main;
          end
        end else begin
          if (run_r == RW'(1)) begin
            // A single held byte joins the literal run.
            wr_en       = 1'b1;
            lit_cnt_nxt = lit_cnt_inc;
            held_nxt    = byte_r;
            if (lit_cnt_inc == CW'(lrrle_pkg::MAX_LITERAL)) begin
              state_nxt = S_LHDR;
            end else begin
              state_nxt = after_main;
            end
          end else begin
            state_nxt = S_RHDR;
          end
        end
      end

      S_LAST: begin
        // End of message: flush whatever is pending.
        flush_nxt = 1'b1;
        if (run_r == RW'(1)) begin
          wr_en       = 1'b1;
          lit_cnt_nxt = lit_cnt_inc;
          state_nxt   = S_LHDR;
        end else if (lit_cnt_r != '0) begin
          state_nxt = S_LHDR;
        end else begin
          state_nxt = S_RHDR;
        end
      end

      S_LHDR: begin
        grp_valid  = 1'b1;
        grp.value  = VW'(lrrle_pkg::LIT_HDR_BASE) + VW'(lit_cnt_r);
        grp.kind   = lrrle_pkg::KIND_LITERAL;
        if (grp_ready) begin
          state_nxt = S_LBYTE;
        end
      end

      S_LBYTE: begin
        grp_valid = 1'b1;
        grp.value = VW'(rd_data);
        grp.kind  = lrrle_pkg::KIND_BYTE;
        if (CW'(idx_r) == lit_last_idx) begin
          grp.step_done = flush_r ? (run_r == RW'(1)) : !last_r;
          grp.code_end  = flush_r && (run_r == RW'(1));
        end
        if (grp_ready) begin
          if (CW'(idx_r) == lit_last_idx) begin
            idx_nxt     = '0;
            lit_cnt_nxt = '0;
            if (!flush_r) begin
              state_nxt = after_main;
            end else if (run_r != RW'(1)) begin
              state_nxt = S_RHDR;
            end else begin
              held_nxt  = '0;
              run_nxt   = '0;
              state_nxt = S_IDLE;
            end
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
      end

      S_RHDR: begin
        grp_valid = 1'b1;
        grp.value = VW'(run_r);
        grp.kind  = lrrle_pkg::KIND_REPEAT;
        if (grp_ready) begin
          state_nxt = S_RBYTE;
        end
      end

      S_RBYTE: begin
        grp_valid     = 1'b1;
        grp.value     = VW'(held_r);
        grp.kind      = lrrle_pkg::KIND_BYTE;
        grp.step_done = flush_r || !last_r;
        grp.code_end  = flush_r;
        if (grp_ready) begin
          if (flush_r) begin
            held_nxt    = '0;
            run_nxt     = '0;
            lit_cnt_nxt = '0;
            state_nxt   = S_IDLE;
          end else begin
            held_nxt  = byte_r;
            run_nxt   = RW'(1);
            state_nxt = after_main;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      held_r    <= '0;
      run_r     <= '0;
      lit_cnt_r <= '0;
      idx_r     <= '0;
      flush_r   <= 1'b0;
      last_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      held_r    <= held_nxt;
      run_r     <= run_nxt;
      lit_cnt_r <= lit_cnt_nxt;
      idx_r     <= idx_nxt;
      flush_r   <= flush_nxt;
      last_r    <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

endmodule

>>> rtl/literal_repeat_rle_encoder_unit.sv
`timescale 1ns / 1ps

// Run-length encoder with literal runs. Each input transaction carries one
// byte (in_tdata) and in_tlast on the final byte of a message. Results are
// three-digit decimal code groups: a repeat header (2..99) then the byte, or
// a literal header (100 + count, up to 32 bytes) then each byte in order.
// out_tuser carries the group kind and a flag on the last group caused by an
// input byte; out_tlast marks the last group of the message. Literal bytes
// are kept in a 32-entry RAM. An input byte passes through S_IDLE and S_STEP,
// and the final byte of a message also through S_LAST; then its groups go out,
// one per cycle while grp_ready is high, through a single output register;
// the next byte is taken once all groups of the current byte have been
// handed to that register.
module literal_repeat_rle_encoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [9:0] group_value, rest zero
  output logic [2:0]  out_tuser,   // [1:0] group_kind, [2] step_done
  output logic        out_tlast
);

  logic              grp_valid;
  logic              grp_ready;
  lrrle_pkg::group_t grp;

  // Step sequencer with the literal store.
  lrrle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .grp_valid (grp_valid),
    .grp       (grp),
    .grp_ready (grp_ready)
  );

  // Output register.
  lrrle_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .grp_valid  (grp_valid),
    .grp        (grp),
    .grp_ready  (grp_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
